@@ hw/rtl/tpa_pkg.sv @@
// shared types and constants for triangle primitive assembly
package tpa_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int MODE_W   = 2;
    localparam int VERTEX_W = 12;
    localparam int EDGE_W   = 16;

    // edge table: one entry per vertex number
    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item codes
    localparam logic [FUNC_W-1:0] FUNC_SET_EDGE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VERTEX   = 2'd2;

    // primitive modes
    localparam logic [MODE_W-1:0] MODE_TRIANGLES = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAN       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STRIP     = 2'd2;

    // one classified command; for vertex commands edge_id holds the table value
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [MODE_W-1:0]   mode;
        logic [VERTEX_W-1:0] vertex_id;
        logic [EDGE_W-1:0]   edge_id;
    } tpa_cmd_t;

endpackage

@@ hw/rtl/tpa_front.sv @@
// front end: input transfer, code check and edge table access
module tpa_front
    import tpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [MODE_W-1:0]   prim_mode,
    input  logic [VERTEX_W-1:0] vertex_index,
    input  logic [EDGE_W-1:0]   edge_index,
    input  logic [QCNT_W-1:0]   queue_count,
    output logic                push_valid,
    output tpa_cmd_t            push_cmd
);

    logic [EDGE_W-1:0] edge_mem [MAX_VERTICES];
    logic [EDGE_W-1:0] rd_data_reg;
    logic              f1_valid_reg;
    tpa_cmd_t          f1_cmd_reg;
    logic [QCNT_W-1:0] committed;
    logic              accept;
    logic              known_func;
    logic [ADDR_W-1:0] table_addr;

    // room check counts the command already in the read stage
    assign committed = queue_count + QCNT_W'(f1_valid_reg);
    assign in_stall  = (committed >= QCNT_W'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;

    assign known_func = (func == FUNC_SET_EDGE) || (func == FUNC_BEGIN)
                     || (func == FUNC_VERTEX);
    assign table_addr = vertex_index[ADDR_W-1:0];

    // read stage valid; unused codes are dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept && known_func;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_cmd_reg <= '{func, prim_mode, vertex_index, edge_index};
        end
    end

    // edge table: write on set-edge, registered read on vertex
    always_ff @(posedge clk)
    begin
        if (accept && (func == FUNC_SET_EDGE))
        begin
            edge_mem[table_addr] <= edge_index;
        end
        if (accept && (func == FUNC_VERTEX))
        begin
            rd_data_reg <= edge_mem[table_addr];
        end
    end

    // vertex commands carry the looked-up edge
    always_comb
    begin
        push_cmd = f1_cmd_reg;
        if (f1_cmd_reg.func == FUNC_VERTEX)
        begin
            push_cmd.edge_id = rd_data_reg;
        end
    end

    assign push_valid = f1_valid_reg;

    // a stalled input never reaches the read stage
    a_no_stage_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> !f1_valid_reg)
        else $error("read stage loaded while input stalled");

endmodule

@@ hw/rtl/tpa_queue.sv @@
// command queue between front end and assembly back end
module tpa_queue
    import tpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tpa_cmd_t          push_cmd,
    input  logic              pop,
    output logic              head_valid,
    output tpa_cmd_t          head_cmd,
    output logic [QCNT_W-1:0] count
);

    tpa_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // occupancy
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    // front end reserves room before every push
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/tpa_back.sv @@
// back end: held vertices, triangle assembly and output register
module tpa_back
    import tpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  tpa_cmd_t            head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VERTEX_W-1:0] tri_vertex_a,
    output logic [VERTEX_W-1:0] tri_vertex_b,
    output logic [VERTEX_W-1:0] tri_vertex_c,
    output logic [EDGE_W-1:0]   tri_edge_a,
    output logic [EDGE_W-1:0]   tri_edge_b,
    output logic [EDGE_W-1:0]   tri_edge_c
);

    logic [MODE_W-1:0]   mode_reg;
    logic [MODE_W-1:0]   mode_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                parity_reg;
    logic                parity_next;
    logic [VERTEX_W-1:0] hv_reg  [3];
    logic [VERTEX_W-1:0] hv_next [3];
    logic [EDGE_W-1:0]   he_reg  [3];
    logic [EDGE_W-1:0]   he_next [3];
    logic [VERTEX_W-1:0] hv_w    [3];
    logic [EDGE_W-1:0]   he_w    [3];
    logic [VERTEX_W-1:0] tv      [3];
    logic [EDGE_W-1:0]   te      [3];
    logic [1:0]          slot;
    logic [1:0]          count_inc;
    logic                emit;
    logic                process;

    logic                out_valid_reg;
    logic [VERTEX_W-1:0] out_v_reg [3];
    logic [EDGE_W-1:0]   out_e_reg [3];

    // take the head command when the output register can hold a result
    assign process = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = process;

    assign slot      = count_reg[1] ? 2'd2 : count_reg;
    assign count_inc = (count_reg == 2'd3) ? 2'd3 : count_reg + 2'd1;

    // assembly step for the head command
    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        parity_next = parity_reg;
        emit        = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            hv_next[k] = hv_reg[k];
            he_next[k] = he_reg[k];
            hv_w[k]    = hv_reg[k];
            he_w[k]    = he_reg[k];
        end
        hv_w[slot] = head_cmd.vertex_id;
        he_w[slot] = head_cmd.edge_id;
        for (int k = 0; k < 3; k++)
        begin
            tv[k] = hv_w[k];
            te[k] = he_w[k];
        end

        unique case (head_cmd.func)
            FUNC_SET_EDGE:
            begin
                // keep held copies in step with the table
                for (int k = 0; k < 3; k++)
                begin
                    if (hv_reg[k][ADDR_W-1:0] == head_cmd.vertex_id[ADDR_W-1:0])
                    begin
                        he_next[k] = head_cmd.edge_id;
                    end
                end
            end
            FUNC_BEGIN:
            begin
                mode_next   = head_cmd.mode;
                count_next  = 2'd0;
                parity_next = 1'b0;
            end
            FUNC_VERTEX:
            begin
                count_next = count_inc;
                for (int k = 0; k < 3; k++)
                begin
                    hv_next[k] = hv_w[k];
                    he_next[k] = he_w[k];
                end
                if (count_inc == 2'd3)
                begin
                    emit = 1'b1;
                    unique case (mode_reg)
                        MODE_FAN:
                        begin
                            hv_next[1] = hv_w[2];
                            he_next[1] = he_w[2];
                        end
                        MODE_STRIP:
                        begin
                            // odd strip triangles come out reversed
                            if (parity_reg)
                            begin
                                tv[0] = hv_w[2];
                                tv[2] = hv_w[0];
                                te[0] = he_w[2];
                                te[2] = he_w[0];
                            end
                            parity_next = ~parity_reg;
                            hv_next[0]  = hv_w[1];
                            he_next[0]  = he_w[1];
                            hv_next[1]  = hv_w[2];
                            he_next[1]  = he_w[2];
                        end
                        default:
                        begin
                            count_next = 2'd0;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // assembly control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TRIANGLES;
            count_reg     <= 2'd0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                hv_reg[k] <= '0;
            end
        end
        else
        begin
            if (process)
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                parity_reg <= parity_next;
                for (int k = 0; k < 3; k++)
                begin
                    hv_reg[k] <= hv_next[k];
                end
            end
            if (process && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // held edges and result payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            for (int k = 0; k < 3; k++)
            begin
                he_reg[k] <= he_next[k];
            end
        end
        if (process && emit)
        begin
            for (int k = 0; k < 3; k++)
            begin
                out_v_reg[k] <= tv[k];
                out_e_reg[k] <= te[k];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign tri_vertex_a = out_v_reg[0];
    assign tri_vertex_b = out_v_reg[1];
    assign tri_vertex_c = out_v_reg[2];
    assign tri_edge_a   = out_e_reg[0];
    assign tri_edge_b   = out_e_reg[1];
    assign tri_edge_c   = out_e_reg[2];

    // separate triangles restart after each triangle
    a_list_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (process && emit && (mode_reg != MODE_FAN) && (mode_reg != MODE_STRIP))
        |=> (count_reg == 2'd0))
        else $error("list mode did not restart after triangle");

    // fan and strip keep three vertices after a triangle
    a_chain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (process && emit && ((mode_reg == MODE_FAN) || (mode_reg == MODE_STRIP)))
        |=> (count_reg == 2'd3))
        else $error("fan or strip lost held vertices");

endmodule

@@ hw/rtl/triangle_primitive_assembly_unit.sv @@
// top level of triangle primitive assembly
//
//  channel | side   | fields                                        | transfer when
//  in      | input  | func prim_mode vertex_index edge_index        | in_valid & !in_stall
//  out     | output | tri_vertex_a/b/c tri_edge_a/b/c               | out_valid & !out_stall
//
// one item per cycle sustained while out_stall is low; out_valid rises once the last
// vertex of a triangle is through the edge table read register, queue and output register
// the edge table is one 4096 x 16 memory with at most one write or one read per item
// reset clears mode, held count, strip parity and held vertices; table contents
// are undefined until written, and no clearing pass runs
// a stalled output backs up the four-entry queue, then in_stall rises
module triangle_primitive_assembly_unit
    import tpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [MODE_W-1:0]   prim_mode,
    input  logic [VERTEX_W-1:0] vertex_index,
    input  logic [EDGE_W-1:0]   edge_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VERTEX_W-1:0] tri_vertex_a,
    output logic [VERTEX_W-1:0] tri_vertex_b,
    output logic [VERTEX_W-1:0] tri_vertex_c,
    output logic [EDGE_W-1:0]   tri_edge_a,
    output logic [EDGE_W-1:0]   tri_edge_b,
    output logic [EDGE_W-1:0]   tri_edge_c
);

    logic              push_valid;
    tpa_cmd_t          push_cmd;
    logic              pop;
    logic              head_valid;
    tpa_cmd_t          head_cmd;
    logic [QCNT_W-1:0] queue_count;

    // transfer, code check and edge table
    tpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .prim_mode    (prim_mode),
        .vertex_index (vertex_index),
        .edge_index   (edge_index),
        .queue_count  (queue_count),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd)
    );

    // decoupling queue
    tpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .count      (queue_count)
    );

    // triangle assembly and output register
    tpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tri_vertex_a (tri_vertex_a),
        .tri_vertex_b (tri_vertex_b),
        .tri_vertex_c (tri_vertex_c),
        .tri_edge_a   (tri_edge_a),
        .tri_edge_b   (tri_edge_b),
        .tri_edge_c   (tri_edge_c)
    );

endmodule

@@ bench/tb_top.sv @@
// testbench for triangle_primitive_assembly_unit: directed table, random vertex streams, self-checking
module tb_top;
    import tpa_pkg::*;

    // codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 470;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 20;

    // one emitted triangle
    typedef struct packed {
        logic [VERTEX_W-1:0] va;
        logic [VERTEX_W-1:0] vb;
        logic [VERTEX_W-1:0] vc;
        logic [EDGE_W-1:0]   ea;
        logic [EDGE_W-1:0]   eb;
        logic [EDGE_W-1:0]   ec;
    } tri_t;

    // one row of the directed table; fixed_tri is used only when has_fixed is set
    typedef struct packed {
        logic [FUNC_W-1:0]   f;
        logic [MODE_W-1:0]   m;
        logic [VERTEX_W-1:0] v;
        logic [EDGE_W-1:0]   e;
        logic                has_fixed;
        tri_t                fixed_tri;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [MODE_W-1:0]   prim_mode;
    logic [VERTEX_W-1:0] vertex_index;
    logic [EDGE_W-1:0]   edge_index;
    logic                out_valid;
    logic                out_stall;
    logic [VERTEX_W-1:0] tri_vertex_a;
    logic [VERTEX_W-1:0] tri_vertex_b;
    logic [VERTEX_W-1:0] tri_vertex_c;
    logic [EDGE_W-1:0]   tri_edge_a;
    logic [EDGE_W-1:0]   tri_edge_b;
    logic [EDGE_W-1:0]   tri_edge_c;

    triangle_primitive_assembly_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .prim_mode    (prim_mode),
        .vertex_index (vertex_index),
        .edge_index   (edge_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tri_vertex_a (tri_vertex_a),
        .tri_vertex_b (tri_vertex_b),
        .tri_vertex_c (tri_vertex_c),
        .tri_edge_a   (tri_edge_a),
        .tri_edge_b   (tri_edge_b),
        .tri_edge_c   (tri_edge_c)
    );

    // assembler state mirrored on the bench side
    logic [MODE_W-1:0]   asm_mode;
    logic [1:0]          asm_count;
    logic [VERTEX_W-1:0] asm_held [3];
    logic                asm_flip;
    logic [EDGE_W-1:0]   edge_table [MAX_VERTICES];

    // vertices whose edge entry has been written; only these go out as vertex transfers
    bit                  vtx_written [MAX_VERTICES];
    logic [VERTEX_W-1:0] vtx_pool [$];

    tri_t tri_expected [$];
    int   error_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_req;

    // directed table: extremes, every command, every mode, unused codes, edge rewrite
    stim_row_t dir_rows [0:24] = '{
        '{FUNC_SET_EDGE, MODE_TRIANGLES, 12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_SET_EDGE, MODE_TRIANGLES, 12'd4095, 16'hFFFF, 1'b0, '0},
        '{FUNC_SET_EDGE, MODE_TRIANGLES, 12'd1,    16'h0001, 1'b0, '0},
        '{FUNC_SET_EDGE, MODE_TRIANGLES, 12'd2,    16'h8000, 1'b0, '0},
        // vertices before any begin: separate triangles
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd4095, 16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd1,    16'h0000, 1'b1,
          '{12'd0, 12'd4095, 12'd1, 16'h0000, 16'hFFFF, 16'h0001}},
        // unused command code is dropped
        '{FUNC_UNUSED,   MODE_UNUSED,    12'hFFF,  16'hFFFF, 1'b0, '0},
        // fan
        '{FUNC_BEGIN,    MODE_FAN,       12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd2,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd1,    16'h0000, 1'b1,
          '{12'd2, 12'd0, 12'd1, 16'h8000, 16'h0000, 16'h0001}},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd4095, 16'h0000, 1'b1,
          '{12'd2, 12'd1, 12'd4095, 16'h8000, 16'h0001, 16'hFFFF}},
        // strip, second triangle reversed
        '{FUNC_BEGIN,    MODE_STRIP,     12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd1,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd2,    16'h0000, 1'b1,
          '{12'd0, 12'd1, 12'd2, 16'h0000, 16'h0001, 16'h8000}},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd4095, 16'h0000, 1'b1,
          '{12'd4095, 12'd2, 12'd1, 16'hFFFF, 16'h8000, 16'h0001}},
        // rewrite the edge of a held vertex
        '{FUNC_SET_EDGE, MODE_TRIANGLES, 12'd4095, 16'h1234, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd0,    16'h0000, 1'b1,
          '{12'd2, 12'd4095, 12'd0, 16'h8000, 16'h1234, 16'h0000}},
        // unused mode code assembles separate triangles
        '{FUNC_BEGIN,    MODE_UNUSED,    12'd0,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd1,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd2,    16'h0000, 1'b0, '0},
        '{FUNC_VERTEX,   MODE_TRIANGLES, 12'd4095, 16'h0000, 1'b1,
          '{12'd1, 12'd2, 12'd4095, 16'h0001, 16'h8000, 16'h1234}},
        '{FUNC_BEGIN,    MODE_TRIANGLES, 12'd0,    16'h0000, 1'b0, '0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** triangle_primitive_assembly_unit: FAILED **");
            $finish;
        end
    end

    // one mismatch line, counted
    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // advance the assembler by one accepted transfer; returns 1 when a triangle comes out
    function automatic bit assemble_triangle(input logic [FUNC_W-1:0] f,
                                             input logic [MODE_W-1:0] m,
                                             input logic [VERTEX_W-1:0] v,
                                             input logic [EDGE_W-1:0] e,
                                             output tri_t tri_out);
        logic [VERTEX_W-1:0] tv [3];
        int slot;
        tri_out = '0;
        case (f)
            FUNC_SET_EDGE:
            begin
                edge_table[v] = e;
                return 1'b0;
            end
            FUNC_BEGIN:
            begin
                asm_mode  = m;
                asm_count = 2'd0;
                asm_flip  = 1'b0;
                return 1'b0;
            end
            FUNC_VERTEX: ;
            default: return 1'b0;
        endcase

        // shift into the held registers, count saturates at three
        slot = (asm_count < 2) ? asm_count : 2;
        asm_held[slot] = v;
        if (asm_count < 3)
            asm_count++;
        if (asm_count < 3)
            return 1'b0;

        tv = asm_held;
        if (asm_mode == MODE_FAN)
        begin
            asm_held[1] = asm_held[2];
        end
        else if (asm_mode == MODE_STRIP)
        begin
            if (asm_flip)
            begin
                tv[0] = asm_held[2];
                tv[2] = asm_held[0];
            end
            asm_flip    = ~asm_flip;
            asm_held[0] = asm_held[1];
            asm_held[1] = asm_held[2];
        end
        else
        begin
            asm_count = 2'd0;
        end

        // edges are looked up when the triangle is emitted
        tri_out = '{tv[0], tv[1], tv[2], edge_table[tv[0]], edge_table[tv[1]], edge_table[tv[2]]};
        return 1'b1;
    endfunction

    // offer one transfer at a falling edge, wait for acceptance, record the expectation
    task automatic send_command(input logic [FUNC_W-1:0] f,
                                input logic [MODE_W-1:0] m,
                                input logic [VERTEX_W-1:0] v,
                                input logic [EDGE_W-1:0] e,
                                input logic has_fixed,
                                input tri_t fixed_tri);
        tri_t got_tri;
        bit   emits;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        prim_mode    <= m;
        vertex_index <= v;
        edge_index   <= e;
        do
            @(posedge clk);
        while (in_stall);
        emits = assemble_triangle(f, m, v, e, got_tri);
        if (has_fixed)
            tri_expected.insert(tri_expected.size(), fixed_tri);
        else if (emits)
            tri_expected.insert(tri_expected.size(), got_tri);
        if (f == FUNC_SET_EDGE && !vtx_written[v])
        begin
            vtx_written[v] = 1'b1;
            vtx_pool.insert(vtx_pool.size(), v);
        end
        @(negedge clk);
    endtask

    // hold the sender until every triangle has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tri_expected.size() != 0);
    endtask

    // receiver stall, with a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin : check_out
        tri_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tri_expected.size() == 0)
                flag_mismatch("triangle with none expected");
            else
            begin
                want = tri_expected.pop_front();
                if (tri_vertex_a !== want.va)
                    flag_mismatch($sformatf("vertex a %0d want %0d", tri_vertex_a, want.va));
                if (tri_vertex_b !== want.vb)
                    flag_mismatch($sformatf("vertex b %0d want %0d", tri_vertex_b, want.vb));
                if (tri_vertex_c !== want.vc)
                    flag_mismatch($sformatf("vertex c %0d want %0d", tri_vertex_c, want.vc));
                if (tri_edge_a !== want.ea)
                    flag_mismatch($sformatf("edge a %0h want %0h", tri_edge_a, want.ea));
                if (tri_edge_b !== want.eb)
                    flag_mismatch($sformatf("edge b %0h want %0h", tri_edge_b, want.eb));
                if (tri_edge_c !== want.ec)
                    flag_mismatch($sformatf("edge c %0h want %0h", tri_edge_c, want.ec));
            end
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int sent;
        int pick;
        int run_len;
        bit hold_done;
        bit mid_drained;
        logic [FUNC_W-1:0]   f;
        logic [MODE_W-1:0]   m;
        logic [VERTEX_W-1:0] v;
        logic [EDGE_W-1:0]   e;

        error_count   = 0;
        cycle_count   = 0;
        hold_req      = 0;
        hold_done     = 1'b0;
        mid_drained   = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_SET_EDGE;
        prim_mode     = MODE_TRIANGLES;
        vertex_index  = '0;
        edge_index    = '0;
        asm_mode      = MODE_TRIANGLES;
        asm_count     = 2'd0;
        asm_flip      = 1'b0;
        asm_held      = '{default: '0};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (dir_rows[i])
            send_command(dir_rows[i].f, dir_rows[i].m, dir_rows[i].v, dir_rows[i].e,
                         dir_rows[i].has_fixed, dir_rows[i].fixed_tri);

        // random streams: receiver-idle heavy, sender-idle heavy, then no idling
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 25 : 0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // most runs start with a begin; the rest continue the current primitive
                if ($urandom_range(99) < 85)
                begin
                    pick = $urandom_range(15);
                    m = (pick < 14) ? MODE_W'(pick % 3) : MODE_UNUSED;
                    send_command(FUNC_BEGIN, m, VERTEX_W'($urandom_range(4095)),
                                 EDGE_W'($urandom_range(65535)), 1'b0, '0);
                    sent++;
                end
                run_len = $urandom_range(1, 12);
                repeat (run_len)
                begin
                    pick = $urandom_range(99);
                    m = MODE_W'($urandom_range(3));
                    e = EDGE_W'($urandom_range(65535));
                    if (pick < 8)
                    begin
                        f = FUNC_SET_EDGE;
                        v = VERTEX_W'($urandom_range(4095));
                    end
                    else if (pick < 12)
                    begin
                        // rewrite the edge of a vertex still held
                        f = FUNC_SET_EDGE;
                        v = asm_held[$urandom_range(2)];
                    end
                    else if (pick < 15)
                    begin
                        f = FUNC_UNUSED;
                        v = VERTEX_W'($urandom_range(4095));
                    end
                    else
                    begin
                        f = FUNC_VERTEX;
                        v = vtx_pool[$urandom_range(vtx_pool.size() - 1)];
                    end
                    send_command(f, m, v, e, 1'b0, '0);
                    if (f != FUNC_UNUSED)
                        sent++;
                end

                // long receiver hold-off while the sender keeps going
                if (phase == 2 && !hold_done && sent > 150)
                begin
                    hold_req  = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                // sender pause until all triangles are out
                if (phase == 0 && !mid_drained && sent > 200)
                begin
                    wait_for_drain();
                    mid_drained = 1'b1;
                end
            end
            wait_for_drain();
        end

        // let any stray output show up
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("** triangle_primitive_assembly_unit: PASSED **");
        else
            $display("** triangle_primitive_assembly_unit: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tpa_pkg.sv
hw/rtl/tpa_front.sv
hw/rtl/tpa_queue.sv
hw/rtl/tpa_back.sv
hw/rtl/triangle_primitive_assembly_unit.sv
bench/tb_top.sv
